/* rtl/bclpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclpd_pkg
// Shared types and constants of the button click / long-press detector.
// ----------------------------------------------------------------------------
package bclpd_pkg;

  localparam int MASK_W      = 4;
  localparam int LED_W       = 2 * MASK_W;
  localparam int DB_W        = 4;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_BUTTONS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

  localparam logic [DB_W-1:0]   DEBOUNCE_RST = 4'd3;
  localparam logic [TICK_W-1:0] LONG_RST     = 16'd30;
  localparam logic [TICK_W-1:0] GAP_RST      = 16'd15;

  typedef struct packed {
    logic [DB_W-1:0]   db_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic long_press;
  } evt_t;

endpackage

/* rtl/bclpd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclpd_if
// Valid/ready channels carrying the input and result words.
// ----------------------------------------------------------------------------
interface bclpd_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bclpd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] single_click_mask;
  logic [3:0] double_click_mask;
  logic [3:0] long_press_mask;
  logic [7:0] led_bits;

  modport source (output valid, output single_click_mask, output double_click_mask,
                  output long_press_mask, output led_bits, input ready);
  modport sink   (input valid, input single_click_mask, input double_click_mask,
                  input long_press_mask, input led_bits, output ready);
endinterface

/* rtl/button_click_long_press_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_long_press_detector_unit
// Per-tick debounce and single / double / long-press detection of buttons.
//
// Usage: each word on in_i carries one tick of raw active-low button levels.
// Every word accepted gives exactly one result word on out_o: the single,
// double and long-press masks of that tick and the LED toggle flags after it.
// One lane per button updates in the accept cycle; the merge stage registers
// the result, so a result appears in the cycle after its input word is taken.
// Throughput is one word per cycle; in_i.ready stays high while the result
// register is empty or being drained in the same cycle. When out_o stalls,
// the held result stays put and in_i.ready drops until it is taken.
// Thresholds are written on cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle: index 0 debounce ticks, 1 long-press ticks, 2 click gap.
// Reset (rst_ni low, async) releases all buttons, clears counters and LED
// flags, empties the result register and restores default thresholds.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_unit
  import bclpd_pkg::*;
#(
  parameter int BUTTONS = NUM_BUTTONS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bclpd_in_if.sink              in_i,
  bclpd_out_if.source           out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  evt_t evt [BUTTONS];
  logic step;
  logic in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.db_ticks   <= DEBOUNCE_RST;
      cfg_q.long_ticks <= LONG_RST;
      cfg_q.gap_ticks  <= GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.db_ticks   <= cfg_data_i[DB_W-1:0];
        CFG_LONG:     cfg_q.long_ticks <= cfg_data_i[TICK_W-1:0];
        CFG_GAP:      cfg_q.gap_ticks  <= cfg_data_i[TICK_W-1:0];
        default:      ;
      endcase
    end
  end

  assign step       = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    bclpd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .raw_i  (in_i.pin_levels[b]),
      .cfg_i  (cfg_q),
      .evt_o  (evt[b])
    );
  end

  bclpd_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .evt_i       (evt),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .single_o    (out_o.single_click_mask),
    .double_o    (out_o.double_click_mask),
    .long_o      (out_o.long_press_mask),
    .led_o       (out_o.led_bits)
  );

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_o.valid)
    else $error("accepted word did not produce a result");

  a_single_double_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.single_click_mask & out_o.double_click_mask) == '0))
    else $error("single and double click on the same button");

  a_long_click_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.long_press_mask &
                      (out_o.single_click_mask | out_o.double_click_mask)) == '0))
    else $error("long press and click on the same button");

  a_led_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(out_o.led_bits))
    else $error("LED flags changed without an accepted word");
`endif

endmodule

/* rtl/bclpd_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclpd_lane
// One button: debounce plus idle / pressed / release-wait classifier.
// ----------------------------------------------------------------------------
module bclpd_lane
  import bclpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic raw_i,
  input  cfg_t cfg_i,
  output evt_t evt_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_WAIT    = 2'd2;

  localparam logic [DB_W-1:0]   DB_MAX   = '1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [1:0]        CC_MAX   = 2'd3;

  logic              level_q, level_d;
  logic [DB_W-1:0]   db_cnt_q, db_cnt_d, db_inc;
  logic [TICK_W-1:0] tick_q, tick_d, tick_inc;
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        clicks_q, clicks_d;

  always_comb begin
    level_d  = level_q;
    db_cnt_d = db_cnt_q;
    tick_d   = tick_q;
    phase_d  = phase_q;
    clicks_d = clicks_q;
    evt_o    = '0;

    tick_inc = (phase_q != PH_IDLE && phase_q != 2'd3 && tick_q != TICK_MAX)
               ? tick_q + 1'b1 : tick_q;
    tick_d   = tick_inc;

    db_inc = (db_cnt_q != DB_MAX) ? db_cnt_q + 1'b1 : db_cnt_q;
    if (level_q != raw_i) begin
      if (db_inc >= cfg_i.db_ticks) begin
        level_d  = raw_i;
        db_cnt_d = '0;
      end else begin
        db_cnt_d = db_inc;
      end
    end else begin
      db_cnt_d = '0;
    end

    unique case (phase_q)
      PH_PRESSED: begin
        if (level_d) begin
          if (tick_inc >= cfg_i.long_ticks) begin
            evt_o.long_press = 1'b1;
            phase_d          = PH_IDLE;
          end else begin
            tick_d  = '0;
            phase_d = PH_WAIT;
          end
        end else if (tick_inc >= cfg_i.long_ticks) begin
          clicks_d = '0;
        end
      end
      PH_WAIT: begin
        if (tick_inc >= cfg_i.gap_ticks) begin
          phase_d            = PH_IDLE;
          evt_o.single_click = (clicks_q == 2'd1);
          evt_o.double_click = (clicks_q == 2'd2);
        end else if (!level_d) begin
          if (clicks_q != CC_MAX) clicks_d = clicks_q + 1'b1;
          tick_d  = '0;
          phase_d = PH_PRESSED;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (!level_d) begin
          tick_d   = '0;
          clicks_d = 2'd1;
          phase_d  = PH_PRESSED;
        end
      end
    endcase

    if (!step_i) evt_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= 1'b1;
      db_cnt_q <= '0;
      tick_q   <= '0;
      phase_q  <= PH_IDLE;
      clicks_q <= '0;
    end else if (step_i) begin
      level_q  <= level_d;
      db_cnt_q <= db_cnt_d;
      tick_q   <= tick_d;
      phase_q  <= phase_d;
      clicks_q <= clicks_d;
    end
  end

endmodule

/* rtl/bclpd_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclpd_merge
// Gathers lane events into masks, toggles LED flags, holds the result word.
// ----------------------------------------------------------------------------
module bclpd_merge
  import bclpd_pkg::*;
#(
  parameter int BUTTONS = NUM_BUTTONS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  evt_t               evt_i [BUTTONS],
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output logic [MASK_W-1:0]  single_o,
  output logic [MASK_W-1:0]  double_o,
  output logic [MASK_W-1:0]  long_o,
  output logic [LED_W-1:0]   led_o
);

  logic [MASK_W-1:0] single_m, double_m, long_m;
  logic [LED_W-1:0]  led_q, led_d;
  logic              valid_q;
  logic [MASK_W-1:0] single_q, double_q, long_q;

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < BUTTONS) begin : g_used
      assign single_m[b] = evt_i[b].single_click;
      assign double_m[b] = evt_i[b].double_click;
      assign long_m[b]   = evt_i[b].long_press;
    end else begin : g_unused
      assign single_m[b] = 1'b0;
      assign double_m[b] = 1'b0;
      assign long_m[b]   = 1'b0;
    end
  end

  assign led_d      = led_q ^ {single_m, double_m | long_m};
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      led_q   <= '0;
    end else begin
      if (step_i) begin
        valid_q <= 1'b1;
        led_q   <= led_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      single_q <= single_m;
      double_q <= double_m;
      long_q   <= long_m;
    end
  end

  assign out_valid_o = valid_q;
  assign single_o    = single_q;
  assign double_o    = double_q;
  assign long_o      = long_q;
  assign led_o       = led_q;

endmodule
